FILE: hdl/deqs_pkg.sv
package deqs_pkg;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_SEARCH     = 3'd4,
        MODE_LIST       = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } req_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] element;
        logic [4:0]         occupancy;
        logic               last;
    } rsp_beat_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_R,
        CELL_SHIFT_L,
        CELL_WRITE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     valid;
        logic     is_tail;
        logic     is_slot;
    } cell_ctrl_t;

endpackage

FILE: hdl/double_ended_queue_with_search_unit.sv
// Bounded double-ended queue of signed 32-bit values with membership search.
// Request channel (req_valid, req_stall, req): one beat names an operation and
// a value. Response channel (rsp_valid, rsp_stall, rsp): one beat per result.
// Entries live in a row of CAPACITY cells, front in the first cell; pushes and
// front pops shift or write the row, search compares all cells at once.
// Push, pop, search, unused modes and lists of an empty queue: one response
// beat, registered in the cycle after the request is taken; a new request is
// taken every cycle while the response register drains.
// List: the request is taken, then one beat per stored entry, one per cycle
// while the output is not stalled, read from the front cell while the row
// rotates by one place; after the last beat the row is back in order.
// req_stall stays high until the last beat is registered.
// Reset empties the queue and drops any pending response; cell contents are
// not cleared and are never shown before being written.
// A stalled response holds in the output register; the row does not rotate
// and req_stall stays high while the register is full and stalled.
module double_ended_queue_with_search_unit
    import deqs_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    localparam int CntW = $clog2(CAPACITY + 1);

    typedef enum logic {
        IDLE,
        LIST
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] remain_reg, remain_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_beat_t       rsp_reg, rsp_next;

    cell_op_t           op;
    logic signed [31:0] cell_q [CAPACITY];
    logic [CAPACITY-1:0] hits;
    logic               out_free;
    logic               accept;
    logic               full;
    logic               empty;
    logic [31:0]        occ_wide;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg == LIST) || !out_free;
    assign accept    = req_valid && !req_stall;
    assign full      = count_reg == CntW'(CAPACITY);
    assign empty     = count_reg == '0;
    assign occ_wide  = 32'(count_next);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_ctrl_t         ctrl;
            logic signed [31:0] left_d;
            logic signed [31:0] right_d;

            assign ctrl.op      = op;
            assign ctrl.valid   = CntW'(gi) < count_reg;
            assign ctrl.is_tail = count_reg == CntW'(gi + 1);
            assign ctrl.is_slot = count_reg == CntW'(gi);

            if (gi == 0)
            begin : g_first
                assign left_d = req.value;
            end
            else
            begin : g_mid
                assign left_d = cell_q[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_end
                assign right_d = cell_q[gi];
            end
            else
            begin : g_inner
                assign right_d = cell_q[gi+1];
            end

            deqs_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (cell_q[0]),
                .value      (req.value),
                .data       (cell_q[gi]),
                .hit        (hits[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        op             = CELL_HOLD;

        if (state_reg == LIST)
        begin
            if (out_free)
            begin
                op                = CELL_ROTATE;
                rsp_valid_next    = 1'b1;
                rsp_next.status   = ST_DONE;
                rsp_next.found    = 1'b0;
                rsp_next.element  = cell_q[0];
                rsp_next.last     = remain_reg == CntW'(1);
                remain_next       = remain_reg - CntW'(1);
                if (remain_reg == CntW'(1))
                begin
                    state_next = IDLE;
                end
            end
            rsp_next.occupancy = occ_wide[4:0];
        end
        else if (accept)
        begin
            rsp_valid_next   = 1'b1;
            rsp_next.status  = ST_DONE;
            rsp_next.found   = 1'b0;
            rsp_next.element = '0;
            rsp_next.last    = 1'b1;
            case (mode_t'(req.mode))
                MODE_PUSH_FRONT,
                MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        op         = (mode_t'(req.mode) == MODE_PUSH_FRONT) ?
                                     CELL_SHIFT_R : CELL_WRITE;
                        count_next = count_reg + CntW'(1);
                    end
                end
                MODE_POP_FRONT,
                MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        if (mode_t'(req.mode) == MODE_POP_FRONT)
                        begin
                            op = CELL_SHIFT_L;
                        end
                        count_next = count_reg - CntW'(1);
                    end
                end
                MODE_SEARCH:
                begin
                    rsp_next.found = |hits;
                end
                MODE_LIST:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        // hold the beat back; entries follow from the LIST state
                        rsp_valid_next = 1'b0;
                        remain_next    = count_reg;
                        state_next     = LIST;
                    end
                end
                default: ;
            endcase
            rsp_next.occupancy = occ_wide[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hdl/deqs_cell.sv
module deqs_cell
    import deqs_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic signed [31:0] left_data,
    input  logic signed [31:0] right_data,
    input  logic signed [31:0] head_data,
    input  logic signed [31:0] value,
    output logic signed [31:0] data,
    output logic               hit
);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_SHIFT_R: data_next = left_data;
            CELL_SHIFT_L: data_next = right_data;
            CELL_WRITE:
            begin
                if (ctrl.is_slot)
                begin
                    data_next = value;
                end
            end
            CELL_ROTATE:
            begin
                // the tail takes the old head so the ring is whole after a full pass
                if (ctrl.is_tail)
                begin
                    data_next = head_data;
                end
                else if (ctrl.valid)
                begin
                    data_next = right_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = ctrl.valid && (data_reg == value);

endmodule

FILE: sim/tb_double_ended_queue_with_search_unit.sv
module tb_double_ended_queue_with_search_unit;
    import deqs_pkg::*;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;

    // codes outside the defined operations; the block answers them as no-ops
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_beat_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;

    bit idle_on = 1'b1;

    // mirror of the queue contents
    logic signed [31:0] ring [DEPTH];
    int ring_head  = 0;
    int ring_count = 0;

    rsp_beat_t queued_replies [$];

    int errors       = 0;
    int n_items      = 0;
    int n_beats      = 0;
    int n_hits       = 0;
    int n_full_drops = 0;
    int n_empty      = 0;
    int idle_cycles  = 0;

    double_ended_queue_with_search_unit #(
        .CAPACITY (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_stall <= rst_n && idle_on && ($urandom_range(99) < 12);
    end

    // Apply one operation to the mirror and queue the beats it must produce.
    task automatic run_deque_op(input req_beat_t b);
        rsp_beat_t r;
        int i;
        begin
            r = '0;
            r.last = 1'b1;
            n_items++;
            case (b.mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK:
                begin
                    if (ring_count >= DEPTH)
                    begin
                        r.status = ST_FULL;
                        n_full_drops++;
                    end
                    else
                    begin
                        if (b.mode == MODE_PUSH_FRONT)
                        begin
                            ring_head = (ring_head + DEPTH - 1) % DEPTH;
                            ring[ring_head] = b.value;
                        end
                        else
                            ring[(ring_head + ring_count) % DEPTH] = b.value;
                        ring_count++;
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK:
                begin
                    if (ring_count == 0)
                    begin
                        r.status = ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        if (b.mode == MODE_POP_FRONT)
                            ring_head = (ring_head + 1) % DEPTH;
                        ring_count--;
                    end
                end
                MODE_SEARCH:
                begin
                    for (i = 0; i < ring_count; i++)
                        if (ring[(ring_head + i) % DEPTH] == b.value)
                            r.found = 1'b1;
                    if (r.found)
                        n_hits++;
                end
                MODE_LIST:
                begin
                    if (ring_count == 0)
                    begin
                        r.status = ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        r.occupancy = 5'(ring_count);
                        for (i = 0; i < ring_count; i++)
                        begin
                            r.element = ring[(ring_head + i) % DEPTH];
                            r.last    = (i == ring_count - 1);
                            queued_replies.push_back(r);
                        end
                        return;
                    end
                end
                default:
                    ;
            endcase
            r.occupancy = 5'(ring_count);
            queued_replies.push_back(r);
        end
    endtask

    task automatic send_beat(input logic [2:0] m, input logic signed [31:0] v);
        req_beat_t b;
        begin
            b.mode  = m;
            b.value = v;
            if (idle_on && $urandom_range(99) < 12)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            req_valid <= 1'b1;
            req       <= b;
            do
                @(posedge clk);
            while (req_stall);
            run_deque_op(b);
        end
    endtask

    // Mix full-range, extreme, clustered and already-stored values so searches hit.
    function automatic logic signed [31:0] pick_value();
        int r;
        begin
            r = $urandom_range(9);
            if (r <= 2 || (r >= 7 && ring_count == 0))
                return 32'($urandom);
            if (r == 3)
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            if (r <= 6)
                return int'($urandom_range(16)) - 8;
            return ring[(ring_head + int'($urandom_range(ring_count - 1))) % DEPTH];
        end
    endfunction

    function automatic logic [2:0] pick_mode(input int push_pct);
        int r;
        begin
            if ($urandom_range(99) < push_pct)
                return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            r = $urandom_range(99);
            if (r < 50)
                return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
            if (r < 80)
                return MODE_SEARCH;
            if (r < 93)
                return MODE_LIST;
            return $urandom_range(1) ? MODE_SPARE_B : MODE_SPARE_A;
        end
    endfunction

    task automatic test_empty_queue();
        begin
            send_beat(MODE_POP_FRONT, 32'sd5);
            send_beat(MODE_POP_BACK, -32'sd5);
            send_beat(MODE_LIST, 32'sd0);
            send_beat(MODE_SEARCH, 32'sd0);
        end
    endtask

    task automatic test_spare_modes();
        begin
            send_beat(MODE_SPARE_A, 32'sh7fff_ffff);
            send_beat(MODE_SPARE_B, 32'sh8000_0000);
        end
    endtask

    task automatic test_extremes();
        begin
            send_beat(MODE_PUSH_FRONT, 32'sh8000_0000);
            send_beat(MODE_PUSH_BACK, 32'sh7fff_ffff);
            send_beat(MODE_PUSH_FRONT, 32'sd0);
            send_beat(MODE_PUSH_BACK, -32'sd1);
            send_beat(MODE_SEARCH, 32'sh8000_0000);
            send_beat(MODE_SEARCH, 32'sh7fff_ffff);
            send_beat(MODE_SEARCH, 32'sd1);
            send_beat(MODE_LIST, 32'sd0);
            send_beat(MODE_POP_FRONT, 32'sd0);
            send_beat(MODE_POP_BACK, 32'sd0);
            send_beat(MODE_SEARCH, -32'sd1);
            send_beat(MODE_LIST, 32'sd0);
        end
    endtask

    // Fill past capacity from random ends, list and search, then empty it, pop once more and list.
    task automatic test_fill_and_drain();
        int i;
        begin
            for (i = 0; i < DEPTH + 2; i++)
                send_beat($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
            send_beat(MODE_LIST, 32'sd0);
            send_beat(MODE_SEARCH, pick_value());
            for (i = 0; i < DEPTH + 1; i++)
                send_beat($urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT, pick_value());
            send_beat(MODE_LIST, 32'sd0);
        end
    endtask

    task automatic test_random_mix(input int n, input int push_pct);
        int i;
        begin
            for (i = 0; i < n; i++)
                send_beat(pick_mode(push_pct), pick_value());
        end
    endtask

    task automatic test_back_to_back(input int n);
        begin
            idle_on <= 1'b0;
            test_random_mix(n, 50);
            idle_on <= 1'b1;
        end
    endtask

    // Send four batches, holding the request side after each until every owed beat has come back, then one more.
    task automatic test_pause_until_drained();
        int k;
        begin
            for (k = 0; k < 4; k++)
            begin
                test_random_mix(5, 55);
                req_valid <= 1'b0;
                while (queued_replies.size() != 0)
                    @(posedge clk);
            end
            test_random_mix(5, 55);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        begin
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (queued_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: response beat with nothing owed, expected none, got %p",
                             $time, rsp);
                end
                else
                begin
                    want = queued_replies.pop_front();
                    n_beats++;
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("found", 32'(want.found), 32'(rsp.found));
                    check_field("element", want.element, rsp.element);
                    check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
                    check_field("last", 32'(want.last), 32'(rsp.last));
                end
            end
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_spare_modes();
        test_extremes();
        test_fill_and_drain();
        test_fill_and_drain();
        test_random_mix(100, 45);
        test_random_mix(100, 70);
        test_random_mix(100, 20);
        test_back_to_back(60);
        test_pause_until_drained();
        req_valid <= 1'b0;
        while (queued_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d requests and checked %0d response beats (%0d search hits).",
                 n_items, n_beats, n_hits);
        $display("Pushes dropped on a full queue: %0d; empty-queue replies: %0d.",
                 n_full_drops, n_empty);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
hdl/deqs_pkg.sv
hdl/deqs_cell.sv
hdl/double_ended_queue_with_search_unit.sv
sim/tb_double_ended_queue_with_search_unit.sv
